// ===== src/ptcb_pkg.sv =====
// ptcb_pkg: shared constants, opcodes, register indexes and inter-module structs
// for the pretrigger capture buffer; no dependencies
package ptcb_pkg;

  localparam int MAX_CHANNELS    = 4;
  localparam int CAPACITY_WORDS  = 4096;
  localparam int MAX_READ_FRAMES = 64;

  localparam int WORD_W    = 32;
  localparam int POS_W     = $clog2(CAPACITY_WORDS);
  localparam int CAP_W     = POS_W + 1;
  localparam int RP_W      = CAP_W + 1;
  localparam int CC_W      = 3;
  localparam int LEN_W     = 13;
  localparam int FNUM_W    = 12;
  localparam int CNT_W     = 7;
  localparam int FW_W      = 16;
  localparam int OP_W      = 3;
  localparam int CFG_IDX_W = 2;

  // input beat layout
  localparam int IN_START_LSB = MAX_CHANNELS * WORD_W;
  localparam int IN_COUNT_LSB = IN_START_LSB + FNUM_W;
  localparam int IN_DATA_W    = ((IN_COUNT_LSB + CNT_W + 7) / 8) * 8;

  // output beat layout
  localparam int OUT_ACC_BIT   = 0;
  localparam int OUT_FNUM_LSB  = 1;
  localparam int OUT_CH_LSB    = OUT_FNUM_LSB + FNUM_W;
  localparam int OUT_ARMED_BIT = OUT_CH_LSB + MAX_CHANNELS * WORD_W;
  localparam int OUT_TRIG_BIT  = OUT_ARMED_BIT + 1;
  localparam int OUT_COMP_BIT  = OUT_TRIG_BIT + 1;
  localparam int OUT_DATA_W    = ((OUT_COMP_BIT + 1 + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_FRAMES_1 = CAP_W'(CAPACITY_WORDS / 1);
  localparam logic [CAP_W-1:0] CAP_FRAMES_2 = CAP_W'(CAPACITY_WORDS / 2);
  localparam logic [CAP_W-1:0] CAP_FRAMES_3 = CAP_W'(CAPACITY_WORDS / 3);
  localparam logic [CAP_W-1:0] CAP_FRAMES_4 = CAP_W'(CAPACITY_WORDS / 4);

  localparam logic [CC_W-1:0]  RST_CHANNEL_COUNT     = CC_W'(1);
  localparam logic [LEN_W-1:0] RST_RECORD_LENGTH     = LEN_W'(1024);
  localparam logic [LEN_W-1:0] RST_PRETRIGGER_LENGTH = LEN_W'(0);

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PRETRIGGER_LENGTH = CFG_IDX_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_ARM     = 3'd1,
    OP_DISARM  = 3'd2,
    OP_TRIGGER = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  // one result on its way to the output register
  typedef struct packed {
    logic                    valid;
    logic                    accepted;
    logic                    frame_valid;
    logic [FNUM_W-1:0]       frame_number;
    logic                    last;
    logic                    armed;
    logic                    triggered;
    logic                    complete;
    logic [MAX_CHANNELS-1:0] lane_en;
  } beat_t;

  // bank access for the channel lanes
  typedef struct packed {
    logic                    wr_en;
    logic [MAX_CHANNELS-1:0] wr_lane;
    logic [POS_W-1:0]        wr_addr;
    logic                    rd_en;
    logic [POS_W-1:0]        rd_addr;
  } mem_t;

  function automatic logic [CAP_W-1:0] cap_frames_of(input logic [CC_W-1:0] cc);
    logic [CAP_W-1:0] res;
    unique case (cc)
      CC_W'(1): res = CAP_FRAMES_1;
      CC_W'(2): res = CAP_FRAMES_2;
      CC_W'(3): res = CAP_FRAMES_3;
      CC_W'(4): res = CAP_FRAMES_4;
      default:  res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== src/ptcb_ram.sv =====
// ptcb_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ptcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/ptcb_ctrl.sv =====
// ptcb_ctrl: configuration registers, capture state and read sequencer
// depends on ptcb_pkg
module ptcb_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptcb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptcb_pkg::LEN_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ptcb_pkg::OP_W-1:0]       in_op,
  input  logic [ptcb_pkg::FNUM_W-1:0]     in_start,
  input  logic [ptcb_pkg::CNT_W-1:0]      in_count,
  input  logic                            issue_ok,
  output ptcb_pkg::beat_t                 beat,
  output ptcb_pkg::mem_t                  mem
);
  import ptcb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP_A,
    ST_OFFSET,
    ST_WRAP_B,
    ST_READ
  } state_t;

  state_t state_r, state_nxt;

  logic [CC_W-1:0]  cc_r, cc_nxt;
  logic [LEN_W-1:0] rec_r, rec_nxt;
  logic [LEN_W-1:0] pre_r, pre_nxt;
  logic [POS_W-1:0] wp_r, wp_nxt;
  logic [POS_W-1:0] tp_r, tp_nxt;
  logic [LEN_W-1:0] post_r, post_nxt;
  logic [FW_W-1:0]  fw_r, fw_nxt;
  logic [FW_W-1:0]  fbt_r, fbt_nxt;
  logic             armed_r, armed_nxt;
  logic             trig_r, trig_nxt;
  logic             comp_r, comp_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W-1:0] k_r, k_nxt;
  logic [RP_W-1:0]  rp_r, rp_nxt;

  logic [CAP_W-1:0] cap;
  logic             cfg_ok;
  logic             accept;
  logic             cfg_fire;
  logic             clr;
  op_t              op;
  logic [LEN_W-1:0] post_inc;
  logic [LEN_W:0]   pp;
  logic [CNT_W-1:0] i_inc;
  logic [LEN_W-1:0] k_inc;
  logic             stop_cur;
  logic             stop_next;
  logic             zero_fill;
  logic [POS_W-1:0] rp_step;
  logic [POS_W-1:0] wp_step;

  function automatic logic [RP_W-1:0] wrap(input logic [RP_W-1:0] v,
                                           input logic [CAP_W-1:0] c);
    return (v >= RP_W'(c)) ? (v - RP_W'(c)) : v;
  endfunction

  assign cap    = cap_frames_of(cc_r);
  assign cfg_ok = (cc_r != '0) && (cc_r <= CC_W'(MAX_CHANNELS)) && (pre_r <= rec_r)
                  && (rec_r != '0) && (rec_r <= LEN_W'(cap));
  assign op        = op_t'(in_op);
  assign in_ready  = (state_r == ST_IDLE) && issue_ok && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign post_inc  = post_r + LEN_W'(1);
  assign pp        = {1'b0, pre_r} + {1'b0, post_r};
  assign i_inc     = i_r + CNT_W'(1);
  assign k_inc     = k_r + LEN_W'(1);
  assign stop_cur  = (i_r == cnt_r) || (k_r >= rec_r) || ({1'b0, k_r} >= pp);
  assign stop_next = (i_inc == cnt_r) || (k_inc >= rec_r) || ({1'b0, k_inc} >= pp);
  assign zero_fill = (k_r < pre_r)
                     && (({1'b0, fbt_r} + (FW_W + 1)'(k_r)) < (FW_W + 1)'(pre_r));
  assign rp_step   = (CAP_W'(rp_r[POS_W-1:0]) + CAP_W'(1) == cap) ? '0
                                                                  : rp_r[POS_W-1:0] + POS_W'(1);
  assign wp_step   = (CAP_W'(wp_r) + CAP_W'(1) == cap) ? '0 : wp_r + POS_W'(1);

  always_comb begin
    state_nxt = state_r;
    cc_nxt    = cc_r;
    rec_nxt   = rec_r;
    pre_nxt   = pre_r;
    wp_nxt    = wp_r;
    tp_nxt    = tp_r;
    post_nxt  = post_r;
    fw_nxt    = fw_r;
    fbt_nxt   = fbt_r;
    armed_nxt = armed_r;
    trig_nxt  = trig_r;
    comp_nxt  = comp_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    rp_nxt    = rp_r;
    clr       = 1'b0;
    beat      = '0;
    mem       = '0;
    mem.wr_addr = wp_r;
    mem.rd_addr = rp_r[POS_W-1:0];

    if (cfg_fire) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: begin
          cc_nxt = cfg_data[CC_W-1:0];
          clr    = 1'b1;
        end
        REG_RECORD_LENGTH: begin
          rec_nxt = cfg_data;
          clr     = 1'b1;
        end
        REG_PRETRIGGER_LENGTH: begin
          pre_nxt = cfg_data;
          clr     = 1'b1;
        end
        default: ;
      endcase
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            beat.valid = 1'b1;
            beat.last  = 1'b1;
            if (cfg_ok) begin
              unique case (op)
                OP_WRITE: begin
                  if (armed_r && !comp_r) begin
                    beat.accepted = 1'b1;
                    mem.wr_en     = 1'b1;
                    for (int c = 0; c < MAX_CHANNELS; c++) begin
                      mem.wr_lane[c] = (CC_W'(c) < cc_r);
                    end
                    wp_nxt = wp_step;
                    if (fw_r != '1) begin
                      fw_nxt = fw_r + FW_W'(1);
                    end
                    if (trig_r) begin
                      post_nxt = post_inc;
                      if (post_inc >= rec_r - pre_r) begin
                        comp_nxt = 1'b1;
                      end
                    end
                  end
                end
                OP_ARM: begin
                  clr           = 1'b1;
                  beat.accepted = 1'b1;
                end
                OP_DISARM: begin
                  armed_nxt     = 1'b0;
                  trig_nxt      = 1'b0;
                  comp_nxt      = 1'b0;
                  beat.accepted = 1'b1;
                end
                OP_TRIGGER: begin
                  if (armed_r && !trig_r) begin
                    trig_nxt      = 1'b1;
                    tp_nxt        = wp_r;
                    fbt_nxt       = fw_r;
                    post_nxt      = '0;
                    comp_nxt      = (pre_r >= rec_r);
                    beat.accepted = 1'b1;
                  end
                end
                OP_READ: begin
                  if (trig_r) begin
                    beat.valid = 1'b0;
                    cnt_nxt    = (in_count > CNT_W'(MAX_READ_FRAMES)) ?
                                 CNT_W'(MAX_READ_FRAMES) : in_count;
                    i_nxt      = '0;
                    k_nxt      = LEN_W'(in_start);
                    rp_nxt     = RP_W'(tp_r) + RP_W'(in_start);
                    state_nxt  = ST_WRAP_A;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ST_WRAP_A: begin
          rp_nxt    = wrap(rp_r, cap);
          state_nxt = ST_OFFSET;
        end
        ST_OFFSET: begin
          rp_nxt    = rp_r + RP_W'(cap) - RP_W'(pre_r);
          state_nxt = ST_WRAP_B;
        end
        ST_WRAP_B: begin
          rp_nxt    = wrap(rp_r, cap);
          state_nxt = ST_READ;
        end
        ST_READ: begin
          if (issue_ok) begin
            beat.valid    = 1'b1;
            beat.accepted = 1'b1;
            if ((i_r == '0) && stop_cur) begin
              beat.last = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              beat.frame_valid  = 1'b1;
              beat.frame_number = k_r[FNUM_W-1:0];
              beat.last         = stop_next;
              for (int c = 0; c < MAX_CHANNELS; c++) begin
                beat.lane_en[c] = !zero_fill && (CC_W'(c) < cc_r);
              end
              mem.rd_en = 1'b1;
              i_nxt     = i_inc;
              k_nxt     = k_inc;
              rp_nxt    = RP_W'(rp_step);
              if (stop_next) begin
                state_nxt = ST_IDLE;
              end
            end
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end

    if (clr) begin
      wp_nxt    = '0;
      tp_nxt    = '0;
      post_nxt  = '0;
      fw_nxt    = '0;
      fbt_nxt   = '0;
      armed_nxt = !cfg_fire;
      trig_nxt  = 1'b0;
      comp_nxt  = 1'b0;
    end

    beat.armed     = armed_nxt;
    beat.triggered = trig_nxt;
    beat.complete  = comp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cc_r    <= RST_CHANNEL_COUNT;
      rec_r   <= RST_RECORD_LENGTH;
      pre_r   <= RST_PRETRIGGER_LENGTH;
      wp_r    <= '0;
      tp_r    <= '0;
      post_r  <= '0;
      fw_r    <= '0;
      fbt_r   <= '0;
      armed_r <= 1'b0;
      trig_r  <= 1'b0;
      comp_r  <= 1'b0;
      i_r     <= '0;
      cnt_r   <= '0;
      k_r     <= '0;
      rp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cc_r    <= cc_nxt;
      rec_r   <= rec_nxt;
      pre_r   <= pre_nxt;
      wp_r    <= wp_nxt;
      tp_r    <= tp_nxt;
      post_r  <= post_nxt;
      fw_r    <= fw_nxt;
      fbt_r   <= fbt_nxt;
      armed_r <= armed_nxt;
      trig_r  <= trig_nxt;
      comp_r  <= comp_nxt;
      i_r     <= i_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      rp_r    <= rp_nxt;
    end
  end

  a_rd_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    mem.rd_en |-> (CAP_W'(mem.rd_addr) < cap))
    else $error("ring read address beyond capacity");

  a_complete_needs_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    comp_r |-> trig_r)
    else $error("capture complete without trigger");

  a_post_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    trig_r |-> (pp <= {1'b0, rec_r}))
    else $error("post-trigger frames exceed record");

endmodule

// ===== src/ptcb_merge.sv =====
// ptcb_merge: joins lane read data with result metadata into the output register
// depends on ptcb_pkg
module ptcb_merge (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  ptcb_pkg::beat_t                                      beat,
  input  logic [ptcb_pkg::MAX_CHANNELS-1:0][ptcb_pkg::WORD_W-1:0] lane_data,
  output logic                                                 issue_ok,
  output logic                                                 out_tvalid,
  input  logic                                                 out_tready,
  output logic [ptcb_pkg::OUT_DATA_W-1:0]                      out_tdata,
  output logic [0:0]                                           out_tuser,
  output logic                                                 out_tlast
);
  import ptcb_pkg::*;

  beat_t                 s1_r, s1_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [0:0]            out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  move;

  assign move     = s1_r.valid && (!out_valid_r || out_tready);
  assign issue_ok = !s1_r.valid || !out_valid_r || out_tready;

  always_comb begin
    s1_nxt = s1_r;
    if (beat.valid) begin
      s1_nxt = beat;
    end else if (move) begin
      s1_nxt.valid = 1'b0;
    end

    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    if (move) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[OUT_ACC_BIT]                 = s1_r.accepted;
      out_data_nxt[OUT_FNUM_LSB +: FNUM_W]      = s1_r.frame_number;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        out_data_nxt[OUT_CH_LSB + c * WORD_W +: WORD_W] = s1_r.lane_en[c] ? lane_data[c] : '0;
      end
      out_data_nxt[OUT_ARMED_BIT] = s1_r.armed;
      out_data_nxt[OUT_TRIG_BIT]  = s1_r.triggered;
      out_data_nxt[OUT_COMP_BIT]  = s1_r.complete;
      out_user_nxt[0] = s1_r.frame_valid;
      out_last_nxt    = s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_user_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      s1_r        <= s1_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
      out_user_r  <= out_user_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_issue_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    beat.valid |-> issue_ok)
    else $error("beat issued with the metadata stage full");

  a_no_frame_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r[0]) |-> out_last_r)
    else $error("frameless result not marked last");

endmodule

// ===== src/pretrigger_capture_buffer_core.sv =====
// pretrigger_capture_buffer_core: top level, one ram bank per channel lane plus control
// and output merge; depends on ptcb_pkg, ptcb_ram, ptcb_ctrl, ptcb_merge
// path: metadata stage register, then output register; one bank read per lane per frame
// throughput: one non-read item or read frame beat per cycle, paced by out_tready; inputs
//   wait for config writes; states WRAP_A, OFFSET, WRAP_B set up a read's ring address
// reset: synchronous active-low, clears capture state and loads default registers;
//   sample banks are not cleared
module pretrigger_capture_buffer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptcb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptcb_pkg::LEN_W-1:0]         cfg_data,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_ch0, in_ch1, in_ch2, in_ch3, start_frame, read_count, zero pad
  input  logic [ptcb_pkg::IN_DATA_W-1:0]     in_tdata,
  // opcode
  input  logic [ptcb_pkg::OP_W-1:0]          in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // accepted, frame_number, out_ch0, out_ch1, out_ch2, out_ch3,
  // is_armed, is_triggered, is_complete
  output logic [ptcb_pkg::OUT_DATA_W-1:0]    out_tdata,
  // frame_valid
  output logic [0:0]                         out_tuser,
  output logic                               out_tlast
);
  import ptcb_pkg::*;

  beat_t                               beat;
  mem_t                                mem;
  logic                                issue_ok;
  logic [MAX_CHANNELS-1:0][WORD_W-1:0] lane_data;

  ptcb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_start  (in_tdata[IN_START_LSB +: FNUM_W]),
    .in_count  (in_tdata[IN_COUNT_LSB +: CNT_W]),
    .issue_ok  (issue_ok),
    .beat      (beat),
    .mem       (mem)
  );

  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    localparam int LaneDepth = CAPACITY_WORDS / (g + 1);
    localparam int LaneAw    = (LaneDepth > 1) ? $clog2(LaneDepth) : 1;

    ptcb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LaneDepth)
    ) u_bank (
      .clk     (clk),
      .wr_en   (mem.wr_en && mem.wr_lane[g]),
      .wr_addr (mem.wr_addr[LaneAw-1:0]),
      .wr_data (in_tdata[g * WORD_W +: WORD_W]),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr[LaneAw-1:0]),
      .rd_data (lane_data[g])
    );
  end

  ptcb_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (beat),
    .lane_data  (lane_data),
    .issue_ok   (issue_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for pretrigger_capture_buffer_core, drives ops and config
// writes, mirrors the capture ring to predict every result beat; depends on ptcb_pkg and the rtl
module testbench;
  import ptcb_pkg::*;

  localparam int                   OP_LAST_CODE  = (1 << OP_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = CFG_IDX_W'(3);
  localparam int                   SETTLE_CYCLES = 8;
  localparam int                   QUIET_LIMIT   = 5000;
  localparam int                   HOLD_CYCLES   = 300;
  localparam int                   ROUND_ITEMS   = 20;

  typedef logic [MAX_CHANNELS-1:0][WORD_W-1:0] frame_words_t;

  typedef struct packed {
    logic              accepted;
    logic              frame_valid;
    logic [FNUM_W-1:0] frame_number;
    frame_words_t      words;
    logic              last;
    logic              armed;
    logic              triggered;
    logic              complete;
  } result_beat_t;

  // mirror of the capture ring and its control state
  class capture_mirror;
    logic [WORD_W-1:0] ring_words [CAPACITY_WORDS];
    int unsigned       chans, rec_len, pre_len, cap_frames;
    bit                cfg_ok;
    int unsigned       wr_pos, trig_pos, post_cnt, written, before_trig;
    bit                armed, triggered, complete;
    result_beat_t      awaited [$];
    int                mismatches;

    function new();
      foreach (ring_words[i]) ring_words[i] = '0;
      chans      = RST_CHANNEL_COUNT;
      rec_len    = RST_RECORD_LENGTH;
      pre_len    = RST_PRETRIGGER_LENGTH;
      mismatches = 0;
      restart();
      revalidate();
    endfunction

    function void restart();
      wr_pos      = 0;
      trig_pos    = 0;
      post_cnt    = 0;
      written     = 0;
      before_trig = 0;
      armed       = 0;
      triggered   = 0;
      complete    = 0;
    endfunction

    function void revalidate();
      cfg_ok     = 0;
      cap_frames = 0;
      if (chans == 0 || chans > MAX_CHANNELS) return;
      if (pre_len > rec_len) return;
      cap_frames = CAPACITY_WORDS / chans;
      if (rec_len == 0 || rec_len > cap_frames) return;
      cfg_ok = 1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] value);
      case (idx)
        REG_CHANNEL_COUNT:     chans = value[CC_W-1:0];
        REG_RECORD_LENGTH:     rec_len = value;
        REG_PRETRIGGER_LENGTH: pre_len = value;
        default:               return;
      endcase
      restart();
      revalidate();
    endfunction

    function result_beat_t make_beat(bit acc, bit fv, int unsigned fnum, frame_words_t w,
                                     bit last);
      result_beat_t b;
      b.accepted     = acc;
      b.frame_valid  = fv;
      b.frame_number = FNUM_W'(fnum);
      b.words        = w;
      b.last         = last;
      b.armed        = armed;
      b.triggered    = triggered;
      b.complete     = complete;
      return b;
    endfunction

    function frame_words_t frame_at(int unsigned pos);
      frame_words_t w;
      w = '0;
      for (int c = 0; c < MAX_CHANNELS; c++)
        if (c < chans) w[c] = ring_words[pos * chans + c];
      return w;
    endfunction

    function void read_frames(int unsigned start, int unsigned count);
      result_beat_t held;
      bit           have;
      int unsigned  k;
      frame_words_t w;
      have = 0;
      if (count > MAX_READ_FRAMES) count = MAX_READ_FRAMES;
      for (int unsigned i = 0; i < count; i++) begin
        k = start + i;
        if (k >= rec_len) break;
        if (k < pre_len) begin
          if (before_trig < pre_len - k) w = '0;
          else w = frame_at((trig_pos + cap_frames - pre_len + k) % cap_frames);
        end else begin
          if (k - pre_len >= post_cnt) break;
          w = frame_at((trig_pos + k - pre_len) % cap_frames);
        end
        if (have) awaited.push_back(held);
        held = make_beat(1, 1, k, w, 0);
        have = 1;
      end
      if (!have) begin
        awaited.push_back(make_beat(1, 0, 0, '0, 1));
      end else begin
        held.last = 1;
        awaited.push_back(held);
      end
    endfunction

    // returns 1 when the op is taken
    function bit take_item(logic [OP_W-1:0] op, frame_words_t w, logic [FNUM_W-1:0] start,
                           logic [CNT_W-1:0] count);
      bit acc;
      acc = 0;
      if (!cfg_ok || op > OP_READ) begin
        awaited.push_back(make_beat(0, 0, 0, '0, 1));
        return 0;
      end
      case (op)
        OP_WRITE: begin
          if (armed && !complete) begin
            for (int c = 0; c < MAX_CHANNELS; c++)
              if (c < chans) ring_words[wr_pos * chans + c] = w[c];
            wr_pos = (wr_pos + 1) % cap_frames;
            if (written < 65535) written++;
            if (triggered) begin
              post_cnt++;
              if (post_cnt >= rec_len - pre_len) complete = 1;
            end
            acc = 1;
          end
        end
        OP_ARM: begin
          restart();
          armed = 1;
          acc   = 1;
        end
        OP_DISARM: begin
          armed     = 0;
          triggered = 0;
          complete  = 0;
          acc       = 1;
        end
        OP_TRIGGER: begin
          if (armed && !triggered) begin
            triggered   = 1;
            trig_pos    = wr_pos;
            before_trig = written;
            post_cnt    = 0;
            if (pre_len >= rec_len) complete = 1;
            acc = 1;
          end
        end
        default: begin
          if (triggered) begin
            read_frames(start, count);
            return 1;
          end
        end
      endcase
      awaited.push_back(make_beat(acc, 0, 0, '0, 1));
      return acc;
    endfunction

    function string show(result_beat_t b);
      return $sformatf("acc %b fv %b frame %0d words %h last %b flags %b%b%b", b.accepted,
                       b.frame_valid, b.frame_number, b.words, b.last, b.armed, b.triggered,
                       b.complete);
    endfunction

    function void match_beat(result_beat_t got);
      result_beat_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %s", show(got));
        return;
      end
      want = awaited.pop_front();
      if (got.accepted !== want.accepted || got.frame_valid !== want.frame_valid ||
          got.frame_number !== want.frame_number || got.words !== want.words ||
          got.last !== want.last || got.armed !== want.armed ||
          got.triggered !== want.triggered || got.complete !== want.complete) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [LEN_W-1:0]       cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [0:0]             out_tuser;
  logic                   out_tlast;

  capture_mirror mirror;
  result_beat_t  seen;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            accepted_items;
  int            quiet_cycles;
  int            hold_left;
  bit            hold_request;

  pretrigger_capture_buffer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side: check each beat, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.accepted     = out_tdata[OUT_ACC_BIT];
      seen.frame_valid  = out_tuser[0];
      seen.frame_number = out_tdata[OUT_FNUM_LSB +: FNUM_W];
      seen.words        = out_tdata[OUT_CH_LSB +: MAX_CHANNELS * WORD_W];
      seen.last         = out_tlast;
      seen.armed        = out_tdata[OUT_ARMED_BIT];
      seen.triggered    = out_tdata[OUT_TRIG_BIT];
      seen.complete     = out_tdata[OUT_COMP_BIT];
      mirror.match_beat(seen);
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic frame_words_t rand_words();
    frame_words_t w;
    for (int c = 0; c < MAX_CHANNELS; c++)
      case ($urandom_range(7))
        0:       w[c] = '0;
        1:       w[c] = '1;
        default: w[c] = $urandom;
      endcase
    return w;
  endfunction

  task automatic issue(input logic [OP_W-1:0] op, input frame_words_t w,
                       input logic [FNUM_W-1:0] start, input logic [CNT_W-1:0] count);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'({count, start, w});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mirror.take_item(op, w, start, count)) accepted_items++;
  endtask

  task automatic issue_op(input logic [OP_W-1:0] op);
    issue(op, rand_words(), FNUM_W'($urandom), CNT_W'($urandom));
  endtask

  // wait until every awaited beat is in and the pipeline is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mirror.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned cc, input int unsigned rec, input int unsigned pre);
    write_reg(REG_CHANNEL_COUNT, LEN_W'(cc));
    write_reg(REG_RECORD_LENGTH, LEN_W'(rec));
    write_reg(REG_PRETRIGGER_LENGTH, LEN_W'(pre));
  endtask

  // arm, pre-trigger frames, usually a trigger, post frames, a few reads, some noise
  task automatic capture_round();
    int unsigned       rec, pre;
    logic [FNUM_W-1:0] start;
    logic [CNT_W-1:0]  count;
    rec = mirror.rec_len;
    pre = mirror.pre_len;
    issue_op(OP_ARM);
    repeat ($urandom_range(pre + 3)) issue_op(OP_WRITE);
    if ($urandom_range(3) == 0) issue_op(OP_W'($urandom_range(OP_LAST_CODE)));
    if ($urandom_range(7) != 0) issue_op(OP_TRIGGER);
    repeat ($urandom_range(rec - pre + 2)) issue_op(OP_WRITE);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(3))
        0:       start = '0;
        3:       start = FNUM_W'($urandom);
        default: start = FNUM_W'($urandom_range(rec + 1));
      endcase
      count = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(rec + 2));
      issue(OP_READ, rand_words(), start, count);
    end
    if ($urandom_range(3) == 0) issue_op(OP_DISARM);
  endtask

  // full capture with a long pre-trigger run, then read the whole record back
  task automatic long_capture(input int unsigned cc, input int unsigned rec,
                              input int unsigned pre, input int unsigned pre_writes);
    configure(cc, rec, pre);
    issue_op(OP_ARM);
    repeat (pre_writes) issue_op(OP_WRITE);
    issue_op(OP_TRIGGER);
    repeat (rec - pre + 1) issue_op(OP_WRITE);
    for (int s = 0; s < rec; s += MAX_READ_FRAMES)
      issue(OP_READ, rand_words(), FNUM_W'(s), CNT_W'(MAX_READ_FRAMES));
  endtask

  initial begin
    int start_count;
    mirror         = new();
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    hold_request   = 1'b0;
    hold_left      = 0;
    quiet_cycles   = 0;
    accepted_items = 0;
    send_idle_pct  = 14;
    recv_idle_pct  = 88;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default registers: rejections, then a short capture
    issue_op(OP_READ);
    issue_op(OP_TRIGGER);
    issue_op(OP_WRITE);
    for (int op = OP_READ + 1; op <= OP_LAST_CODE; op++) issue_op(OP_W'(op));
    issue_op(OP_ARM);
    issue(OP_WRITE, '0, '0, '0);
    issue(OP_WRITE, '1, '1, '1);
    issue_op(OP_WRITE);
    issue_op(OP_TRIGGER);
    issue_op(OP_TRIGGER);
    issue_op(OP_WRITE);
    issue_op(OP_WRITE);
    issue(OP_READ, rand_words(), '0, '0);
    issue(OP_READ, rand_words(), '0, '1);
    issue_op(OP_DISARM);
    issue_op(OP_READ);

    // longest record, all of it pre-trigger: complete on trigger, early frames read as zero
    configure(1, CAPACITY_WORDS, CAPACITY_WORDS);
    issue_op(OP_ARM);
    repeat (3) issue_op(OP_WRITE);
    write_reg(REG_SPARE, '1);
    issue_op(OP_TRIGGER);
    issue_op(OP_WRITE);
    issue(OP_READ, rand_words(), FNUM_W'(CAPACITY_WORDS - 3), CNT_W'(5));
    issue(OP_READ, rand_words(), '0, CNT_W'(2));
    issue(OP_READ, rand_words(), '1, CNT_W'(MAX_READ_FRAMES));

    // invalid register sets reject everything
    write_reg(REG_RECORD_LENGTH, LEN_W'(CAPACITY_WORDS + 1));
    issue_op(OP_ARM);
    write_reg(REG_RECORD_LENGTH, LEN_W'(16));
    write_reg(REG_CHANNEL_COUNT, '0);
    issue_op(OP_READ);
    write_reg(REG_CHANNEL_COUNT, LEN_W'(MAX_CHANNELS + 1));
    issue_op(OP_WRITE);
    write_reg(REG_CHANNEL_COUNT, '1);
    issue_op(OP_ARM);
    write_reg(REG_CHANNEL_COUNT, LEN_W'(MAX_CHANNELS));
    write_reg(REG_PRETRIGGER_LENGTH, LEN_W'(17));
    issue_op(OP_TRIGGER);
    write_reg(REG_RECORD_LENGTH, '0);
    issue_op(OP_DISARM);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 88;
        end
        1: begin
          send_idle_pct = 88;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (2) begin
        configure($urandom_range(1, MAX_CHANNELS), $urandom_range(1, 24), 0);
        write_reg(REG_PRETRIGGER_LENGTH, LEN_W'($urandom_range(mirror.rec_len)));
        if (phase == 2) hold_request = 1'b1;
        start_count = accepted_items;
        while (accepted_items - start_count < ROUND_ITEMS) capture_round();
      end
    end

    // all lanes, pre-trigger run longer than the window, whole record read back
    long_capture(MAX_CHANNELS, 24, 8, 12);

    settle();
    if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
